>>> hw/rtl/mpe_pkg.sv
// Shared types and constants for the Meixner polynomial evaluator.
`timescale 1ns / 1ps
`default_nettype none

package mpe_pkg;

  localparam int unsigned PointW  = 16;
  localparam int unsigned DegreeW = 5;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned AccW    = 128;
  localparam int unsigned MulBW   = 49;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PROB   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIALS = 2'd1;

  localparam logic [CfgW-1:0] PROB_RESET   = 16'd32768;
  localparam logic [CfgW-1:0] TRIALS_RESET = 16'd1;

  typedef struct packed {
    logic [PointW-1:0]  point;
    logic [DegreeW-1:0] degree;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     overflow;
  } out_t;

  // Command to the multiply-accumulate unit: acc = init +/- a * b.
  typedef struct packed {
    logic                    start;
    logic                    sub;
    logic signed [63:0]      a;
    logic signed [MulBW-1:0] b;
    logic [AccW-1:0]         init;
  } mac_cmd_t;

  // Command to the divider: rounded num / den.
  typedef struct packed {
    logic            start;
    logic [AccW-1:0] num;
    logic [63:0]     den;
  } div_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/meixner_polynomial_eval.sv
// Top level of the Meixner polynomial evaluator: sequencer, registers and ports.
`timescale 1ns / 1ps
`default_nettype none

// This block evaluates the Meixner polynomial M_n(x; T, p) at an integer point x
// for orders up to MAX_ORDER and returns it as a signed fixed-point number with
// FRAC_BITS fraction bits, saturating on overflow and flagging it. The success
// probability (Q0.16) and trial count are set through the configuration port,
// which always accepts a transfer; a zero in either register is treated as one.
// Orders 0 through 2 use closed forms and higher orders run the three-term
// recurrence. One item is handled at a time and the input is stalled meanwhile.
// Orders 0 and out-of-range orders skip the arithmetic units, and each order
// above 2 adds two passes through the digit-serial multiply-accumulate unit
// and one pass through the bit-serial 128-bit divider, which sets the pace. A
// finished result waits in the output register, and the next item is accepted
// meanwhile.
module meixner_polynomial_eval #(
  parameter int unsigned MAX_ORDER = 31,
  parameter int unsigned FRAC_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire mpe_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output mpe_pkg::out_t                    out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [mpe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mpe_pkg::CfgW-1:0]    cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PT   = 4'd1;
  localparam logic [3:0] S_XM   = 4'd2;
  localparam logic [3:0] S_O1   = 4'd3;
  localparam logic [3:0] S_D2   = 4'd4;
  localparam logic [3:0] S_N2   = 4'd5;
  localparam logic [3:0] S_O2   = 4'd6;
  localparam logic [3:0] S_RA   = 4'd7;
  localparam logic [3:0] S_RB   = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]  state_q, state_d;
  logic        busy_q;
  logic [15:0] prob_q, trials_q;
  logic [15:0] x_q;
  logic [4:0]  n_q;
  logic [31:0] pt_q;
  logic [31:0] xm_q;
  logic [63:0] d_q;
  logic signed [63:0] kp_q, kc_q, res_q;
  logic [4:0]  k_q;
  logic [20:0] kpm_q;
  logic        ovf_q;
  logic        out_valid_q;
  mpe_pkg::out_t out_q;

  logic [15:0] p_eff, t_eff, m_val;
  logic [32:0] ptp;
  logic [33:0] den_rec;
  logic signed [36:0] s_val, cq_val;
  logic signed [32:0] diff1;
  logic        accept, in_busy, out_free, mac_done, div_done, div_ovf, op_done;
  logic [mpe_pkg::AccW-1:0] mac_acc;
  logic signed [63:0] div_quo;
  mpe_pkg::mac_cmd_t mac_cmd;
  mpe_pkg::div_cmd_t div_cmd;

  // Zero in either register behaves as one.
  assign p_eff   = (prob_q == 16'd0) ? 16'd1 : prob_q;
  assign t_eff   = (trials_q == 16'd0) ? 16'd1 : trials_q;
  assign m_val   = 16'(17'h1_0000 - {1'b0, p_eff});
  assign ptp     = {1'b0, pt_q} + {17'd0, p_eff};
  assign den_rec = {2'd0, pt_q} + {13'd0, kpm_q};
  assign s_val   = $signed({3'd0, ptp, 1'b0} + {21'd0, m_val} - {5'd0, xm_q});
  assign cq_val  = $signed({16'd0, k_q, 16'd0} + {3'd0, den_rec} - {5'd0, xm_q});
  assign diff1   = $signed({1'b0, pt_q} - {1'b0, xm_q});

  assign in_busy    = (state_q != S_IDLE);
  assign in_stall_o = in_busy;
  assign accept     = in_valid_i && !in_busy;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Operand selection for the shared arithmetic units.
  always_comb begin
    mac_cmd       = '0;
    mac_cmd.start = !busy_q && (state_q == S_PT || state_q == S_XM || state_q == S_D2 ||
                                state_q == S_N2 || state_q == S_RA || state_q == S_RB);
    case (state_q)
      S_PT: begin
        mac_cmd.a = {48'd0, p_eff};
        mac_cmd.b = {33'd0, t_eff};
      end
      S_XM: begin
        mac_cmd.a = {48'd0, x_q};
        mac_cmd.b = {33'd0, m_val};
      end
      S_D2: begin
        mac_cmd.a = {31'd0, ptp};
        mac_cmd.b = {17'd0, pt_q};
      end
      S_N2: begin
        mac_cmd.init = {64'd0, d_q};
        mac_cmd.sub  = 1'b1;
        mac_cmd.a    = {32'd0, xm_q};
        mac_cmd.b    = {{12{s_val[36]}}, s_val};
      end
      S_RA: begin
        mac_cmd.a = kc_q;
        mac_cmd.b = {{12{cq_val[36]}}, cq_val};
      end
      S_RB: begin
        mac_cmd.init = mac_acc;
        mac_cmd.sub  = 1'b1;
        mac_cmd.a    = kp_q;
        mac_cmd.b    = {28'd0, k_q, 16'd0};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_cmd       = '0;
    div_cmd.start = !busy_q && (state_q == S_O1 || state_q == S_O2 || state_q == S_RD);
    case (state_q)
      S_O1: begin
        div_cmd.num = {{95{diff1[32]}}, diff1} << FRAC_BITS;
        div_cmd.den = {32'd0, pt_q};
      end
      S_O2: begin
        div_cmd.num = mac_acc << FRAC_BITS;
        div_cmd.den = d_q;
      end
      S_RD: begin
        div_cmd.num = mac_acc;
        div_cmd.den = {30'd0, den_rec};
      end
      default: ;
    endcase
  end

  assign op_done = mac_done || div_done;

  // Sequencer: closed forms for low orders, then one recurrence step per lap.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (int'(in_data_i.degree) > int'(MAX_ORDER) ||
              in_data_i.degree == 5'd0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PT;
          end
        end
      end
      S_PT:   if (op_done) state_d = S_XM;
      S_XM:   if (op_done) state_d = S_O1;
      S_O1:   if (op_done) state_d = (n_q == 5'd1) ? S_DONE : S_D2;
      S_D2:   if (op_done) state_d = S_N2;
      S_N2:   if (op_done) state_d = S_O2;
      S_O2:   if (op_done) state_d = (n_q == 5'd2) ? S_DONE : S_RA;
      S_RA:   if (op_done) state_d = S_RB;
      S_RB:   if (op_done) state_d = S_RD;
      S_RD:   if (op_done) state_d = (k_q + 5'd1 == n_q) ? S_DONE : S_RA;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prob_q      <= mpe_pkg::PROB_RESET;
      trials_q    <= mpe_pkg::TRIALS_RESET;
    end else begin
      state_q <= state_d;
      if (mac_cmd.start || div_cmd.start) begin
        busy_q <= 1'b1;
      end else if (op_done) begin
        busy_q <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          mpe_pkg::CFG_PROB:   prob_q   <= cfg_data_i;
          mpe_pkg::CFG_TRIALS: trials_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= in_data_i.point;
      n_q   <= in_data_i.degree;
      ovf_q <= 1'b0;
      res_q <= 64'sd0;
      if (int'(in_data_i.degree) > int'(MAX_ORDER)) begin
        ovf_q <= 1'b1;
      end else if (in_data_i.degree == 5'd0) begin
        res_q <= 64'sd1 <<< FRAC_BITS;
      end
    end
    if (mac_done) begin
      if (state_q == S_PT) pt_q <= mac_acc[31:0];
      if (state_q == S_XM) xm_q <= mac_acc[31:0];
      if (state_q == S_D2) d_q  <= mac_acc[63:0];
    end
    if (div_done) begin
      ovf_q <= ovf_q | div_ovf;
      res_q <= div_quo;
      if (state_q == S_O1) begin
        kp_q <= div_quo;
      end else if (state_q == S_O2) begin
        kc_q  <= div_quo;
        k_q   <= 5'd2;
        kpm_q <= {4'd0, p_eff, 1'b0};
      end else begin
        kp_q  <= kc_q;
        kc_q  <= div_quo;
        k_q   <= k_q + 5'd1;
        kpm_q <= kpm_q + {5'd0, p_eff};
      end
    end
    if (state_q == S_DONE && out_free) begin
      out_q.value    <= res_q;
      out_q.overflow <= ovf_q;
    end
  end

  mpe_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  mpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .done_o (div_done),
    .quo_o  (div_quo),
    .ovf_o  (div_ovf)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/mpe_mac.sv
// Multiply-accumulate unit working through the multiplier in 16-bit digits.
`timescale 1ns / 1ps
`default_nettype none

module mpe_mac (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mpe_pkg::mac_cmd_t     cmd_i,
  output logic                       done_o,
  output logic [mpe_pkg::AccW-1:0]   acc_o
);

  localparam int unsigned BMagW = 48;

  logic [mpe_pkg::AccW-1:0] acc_q;
  logic [63:0]              amag_q;
  logic [BMagW-1:0]         bmag_q;
  logic                     neg_q;
  logic [1:0]               cnt_q;
  logic [1:0]               sh_q;
  logic                     run_q;
  logic                     pv_q;
  logic                     done_q;
  logic [79:0]              prod_q;
  logic [15:0]              chunk;
  logic [mpe_pkg::AccW-1:0] addend;
  logic [63:0]              a_abs;
  logic [mpe_pkg::MulBW-1:0] b_abs;

  assign a_abs = cmd_i.a[63] ? (64'd0 - cmd_i.a) : cmd_i.a;
  assign b_abs = cmd_i.b[mpe_pkg::MulBW-1] ? (49'd0 - cmd_i.b) : cmd_i.b;

  always_comb begin
    case (cnt_q)
      2'd0:    chunk = bmag_q[15:0];
      2'd1:    chunk = bmag_q[31:16];
      default: chunk = bmag_q[47:32];
    endcase
  end

  always_comb begin
    case (sh_q)
      2'd0:    addend = {48'd0, prod_q};
      2'd1:    addend = {32'd0, prod_q, 16'd0};
      default: addend = {16'd0, prod_q, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        run_q <= 1'b1;
        pv_q  <= 1'b0;
        cnt_q <= 2'd0;
      end else if (run_q) begin
        if (cnt_q != 2'd3) begin
          pv_q  <= 1'b1;
          cnt_q <= cnt_q + 2'd1;
        end else begin
          pv_q <= 1'b0;
        end
        if (cnt_q == 2'd3 && pv_q) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q  <= cmd_i.init;
      amag_q <= a_abs;
      bmag_q <= b_abs[BMagW-1:0];
      neg_q  <= cmd_i.a[63] ^ cmd_i.b[mpe_pkg::MulBW-1] ^ cmd_i.sub;
    end else if (run_q) begin
      if (cnt_q != 2'd3) begin
        prod_q <= amag_q * chunk;
        sh_q   <= cnt_q;
      end
      if (pv_q) begin
        acc_q <= acc_q + (addend ^ {mpe_pkg::AccW{neg_q}}) + {127'd0, neg_q};
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/mpe_div.sv
// Restoring divider, one quotient bit a cycle, with rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module mpe_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mpe_pkg::div_cmd_t       cmd_i,
  output logic                         done_o,
  output logic signed [63:0]           quo_o,
  output logic                         ovf_o
);

  logic [127:0] mag_q;
  logic [63:0]  r_q;
  logic [63:0]  den_q;
  logic         neg_q;
  logic [6:0]   cnt_q;
  logic         run_q;
  logic         fin_q;
  logic         done_q;
  logic         ovf_q;
  logic [63:0]  quo_q;
  logic [64:0]  r_sh;
  logic [64:0]  r_nx;
  logic         ge;
  logic         rnd;
  logic [127:0] qr;
  logic         sat;

  assign r_sh = {r_q, mag_q[127]};
  assign ge   = r_sh >= {1'b0, den_q};
  assign r_nx = ge ? (r_sh - {1'b0, den_q}) : r_sh;
  assign rnd  = {r_q, 1'b0} >= {1'b0, den_q};
  assign qr   = mag_q + {127'd0, rnd};
  assign sat  = (qr[127:64] != 64'd0) || (!neg_q && qr[63]) ||
                (neg_q && qr[63:0] > 64'h8000_0000_0000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (cmd_i.start) begin
        run_q <= 1'b1;
        cnt_q <= 7'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      neg_q <= cmd_i.num[127];
      mag_q <= cmd_i.num[127] ? (128'd0 - cmd_i.num) : cmd_i.num;
      den_q <= cmd_i.den;
      r_q   <= 64'd0;
    end else if (run_q) begin
      r_q   <= r_nx[63:0];
      mag_q <= {mag_q[126:0], ge};
    end else if (fin_q) begin
      ovf_q <= sat;
      if (sat) begin
        quo_q <= neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        quo_q <= neg_q ? (64'd0 - qr[63:0]) : qr[63:0];
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

`default_nettype wire

>>> hw/rtl/mpe_checker.sv
// Port-level checks for the Meixner polynomial evaluator and their binding.
`timescale 1ns / 1ps
`default_nettype none

module mpe_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire mpe_pkg::out_t out_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // After a transfer in, the block is busy with that item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // A new result only appears at the end of work on an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in progress");

  // A result leaves only through a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped");

endmodule

bind meixner_polynomial_eval mpe_checker u_mpe_checker (.*);

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the Meixner polynomial evaluator.
`timescale 1ns / 1ps

module tb;

  // Clock, reset and the signals that the block sees. Every input is known from time zero.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  mpe_pkg::in_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [mpe_pkg::CfgIdxW-1:0] cfg_index = mpe_pkg::CFG_PROB;
  logic [mpe_pkg::CfgW-1:0] cfg_data = '0;
  logic in_stall_o;
  logic out_valid_o;
  mpe_pkg::out_t out_data_o;
  logic cfg_ready_o;

  meixner_polynomial_eval u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Points and orders waiting to be offered, and the results that the accepted ones must give.
  mpe_pkg::in_t point_queue[$];
  mpe_pkg::out_t value_queue[$];

  // The testbench's own copy of the two configuration registers.
  logic [mpe_pkg::CfgW-1:0] prob_reg = mpe_pkg::PROB_RESET;
  logic [mpe_pkg::CfgW-1:0] trials_reg = mpe_pkg::TRIALS_RESET;

  // Percentages of cycles in which the sender idles or the receiver stalls.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // A long receiver hold-off is asked for by bumping hold_reqs.
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  // Set inside the quotient helper when a value saturates.
  bit sat_seen;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Rounded quotient num / den, ties away from zero, saturated to 64 bits.
  // The result comes back sign extended to 128 bits so that later steps can use it directly.
  function automatic logic signed [127:0] round_quot(input logic signed [127:0] num,
                                                     input logic [63:0] den);
    logic neg;
    logic [127:0] mag;
    logic [127:0] quo;
    logic [128:0] rem2;
    logic [63:0] res;
    neg = num[127];
    mag = neg ? -num : num;
    quo = mag / den;
    rem2 = {1'b0, mag % den} << 1;
    if (rem2 >= {65'd0, den}) quo = quo + 1;
    if (!neg && quo > 128'h7FFF_FFFF_FFFF_FFFF) begin
      sat_seen = 1'b1;
      res = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (neg && quo > 128'h8000_0000_0000_0000) begin
      sat_seen = 1'b1;
      res = 64'h8000_0000_0000_0000;
    end else begin
      res = neg ? -quo[63:0] : quo[63:0];
    end
    return {{64{res[63]}}, res};
  endfunction

  // Value of the polynomial for one point and order under the current registers.
  // Orders 1 and 2 are single exact fractions; higher orders step the recurrence.
  function automatic mpe_pkg::out_t meixner_value(input mpe_pkg::in_t item);
    logic signed [127:0] p, t, m, xm, s, d, cq, num, order_prev, order_cur, nxt;
    mpe_pkg::out_t res;
    int k;
    p = (prob_reg == 0) ? 128'sd1 : {112'd0, prob_reg};
    t = (trials_reg == 0) ? 128'sd1 : {112'd0, trials_reg};
    m = 128'sd65536 - p;
    xm = {112'd0, item.point} * m;
    sat_seen = 1'b0;
    if (item.degree > 31) begin
      // Orders beyond the supported range are refused with the flag raised.
      res.value = '0;
      res.overflow = 1'b1;
      return res;
    end
    if (item.degree == 0) begin
      res.value = 64'sd1 <<< 32;
      res.overflow = 1'b0;
      return res;
    end
    order_prev = round_quot((p * t - xm) <<< 32, 64'(p * t));
    order_cur = order_prev;
    if (item.degree >= 2) begin
      s = 2 * p * (t + 1) + m - xm;
      d = p * p * t * (t + 1);
      order_cur = round_quot((d - xm * s) <<< 32, d[63:0]);
      for (k = 2; k < item.degree; k++) begin
        cq = k * 128'sd65536 + p * (k + t) - xm;
        num = cq * order_cur - k * 128'sd65536 * order_prev;
        nxt = round_quot(num, 64'(p * (k + t)));
        order_prev = order_cur;
        order_cur = nxt;
      end
    end
    res.value = order_cur[63:0];
    res.overflow = sat_seen;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Sender: offers queued items, holds a stalled transfer steady, idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall_o) value_queue.push_back(meixner_value(in_data));
      if (!in_valid || !in_stall_o) begin
        if (point_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= point_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result transfer against the oldest expectation and drives
  // the stall, either at random or as one long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    mpe_pkg::out_t exp_res;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (value_queue.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_data_o.value));
        end else begin
          exp_res = value_queue.pop_front();
          if (out_data_o.value !== exp_res.value)
            report_mismatch($sformatf("value %h, expected %h",
                                      out_data_o.value, exp_res.value));
          if (out_data_o.overflow !== exp_res.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      out_data_o.overflow, exp_res.overflow));
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_reqs != hold_served) begin
        hold_served <= hold_served + 1;
        hold_left <= 3000;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Waits until every queued item has been taken and every result has come back.
  // The output register has then emptied, so the block is idle.
  task automatic wait_drained();
    while (point_queue.size() > 0 || in_valid || value_queue.size() > 0 || hold_left > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mpe_pkg::CfgIdxW-1:0] idx,
                           input logic [mpe_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == mpe_pkg::CFG_PROB) prob_reg = val;
    else trials_reg = val;
  endtask

  task automatic set_params(input logic [mpe_pkg::CfgW-1:0] prob,
                            input logic [mpe_pkg::CfgW-1:0] trials);
    write_reg(mpe_pkg::CFG_PROB, prob);
    write_reg(mpe_pkg::CFG_TRIALS, trials);
  endtask

  task automatic queue_item(input int unsigned pt, input int unsigned deg);
    mpe_pkg::in_t item;
    item.point = pt[mpe_pkg::PointW-1:0];
    item.degree = deg[mpe_pkg::DegreeW-1:0];
    point_queue.push_back(item);
  endtask

  // Random item: mostly low orders, which finish quickly, with the full range now and then.
  task automatic queue_random_item();
    int unsigned sel;
    int unsigned pt;
    sel = $urandom_range(99);
    pt = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(65535);
    if (sel < 70) queue_item(pt, $urandom_range(6));
    else if (sel < 90) queue_item(pt, $urandom_range(15, 7));
    else queue_item(pt, $urandom_range(31, 16));
  endtask

  task automatic random_phase(input int unsigned idle, input int unsigned stall,
                              input int unsigned count);
    idle_pct = idle;
    stall_pct = stall;
    set_params(16'($urandom_range(65535, 1)), ($urandom_range(1) != 0) ?
               16'($urandom_range(65535, 1)) : 16'($urandom_range(40, 1)));
    repeat (count) queue_random_item();
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // Directed part under the reset settings: every closed form, the first recurrence
    // steps and the highest order, at the smallest and largest points.
    queue_item(0, 0);
    queue_item(65535, 0);
    queue_item(0, 1);
    queue_item(65535, 1);
    queue_item(0, 2);
    queue_item(65535, 2);
    queue_item(7, 3);
    queue_item(65535, 3);
    queue_item(3, 4);
    queue_item(0, 31);
    queue_item(65535, 31);
    wait_drained();

    // The smallest probability with the most trials drives large values to saturation.
    set_params(16'd1, 16'd65535);
    queue_item(65535, 2);
    queue_item(65535, 31);
    queue_item(12345, 5);
    wait_drained();

    set_params(16'd65535, 16'd1);
    queue_item(65535, 1);
    queue_item(65535, 31);
    queue_item(1, 9);
    wait_drained();

    // Zero in either register counts as one.
    set_params(16'd0, 16'd0);
    queue_item(65535, 2);
    queue_item(40000, 6);
    queue_item(2, 31);
    wait_drained();

    set_params(16'd1, 16'd1);
    queue_item(65535, 3);
    queue_item(100, 31);
    wait_drained();

    // Pressure: the receiver holds off for a long stretch while items keep coming, so
    // the output register fills and the input stalls.
    idle_pct = 0;
    stall_pct = 0;
    set_params(mpe_pkg::PROB_RESET, 16'd65535);
    hold_reqs++;
    repeat (8) queue_item($urandom_range(65535), $urandom_range(1));
    wait_drained();

    random_phase(0, 0, 60);
    random_phase(76, 0, 60);
    random_phase(0, 76, 60);
    random_phase(7, 7, 60);
    random_phase(0, 0, 25);

    if (errors == 0) begin
      $display("** meixner_polynomial_eval: PASSED **");
    end else begin
      $display("** meixner_polynomial_eval: FAILED **");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("** meixner_polynomial_eval: FAILED **");
    $finish;
  end

endmodule
